### hdl/sorted_arrival_queue_assert.svh
// Assertion macros shared by the sorted arrival queue modules.
`ifndef SORTED_ARRIVAL_QUEUE_ASSERT_SVH
`define SORTED_ARRIVAL_QUEUE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define SAQ_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define SAQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/saq_pkg.sv
// Types and constants of the sorted arrival queue.
package saq_pkg;

  localparam int KEY_W       = 16;
  localparam int TAG_W       = 8;
  localparam int IDX_W       = 4;
  localparam int SLOT_W      = 4;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_USED_W  = STATUS_W + SLOT_W + KEY_W + TAG_W + CNT_W;
  localparam int OUT_TDATA_W = 40;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;      // latch the input beat
    logic init_ins;     // hole pointer <= count
    logic init_rem;     // pointer <= remove index
    logic rd_below;     // read entry at ptr-1
    logic rd_at;        // read entry at ptr
    logic rd_above;     // read entry at ptr+1
    logic wr_new;       // write new entry at ptr
    logic wr_up;        // move read entry up into ptr, ptr--
    logic wr_down;      // move read entry down into ptr, ptr++
    logic cap_removed;  // keep read entry as the removed one
    logic load_result;  // load output register, update count
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_insert;
    logic full;
    logic bad_index;
    logic ptr_zero;
    logic key_greater;
    logic rem_last;
    logic out_free;
  } sts_t;

endpackage

### hdl/saq_ctrl.sv
// Sequencer for insert and remove passes of the sorted arrival queue.
`include "sorted_arrival_queue_assert.svh"

module saq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output saq_pkg::cmd_t cmd,
  input  saq_pkg::sts_t sts
);
  import saq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CHECK   = 9'b000000010,
    S_INS_RD  = 9'b000000100,
    S_INS_CMP = 9'b000001000,
    S_REM_RD0 = 9'b000010000,
    S_REM_CAP = 9'b000100000,
    S_REM_RD  = 9'b001000000,
    S_REM_CMP = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // no beat is taken while reset is held
  assign s_tready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_insert) begin
          if (sts.full) begin
            state_next = S_FIN;
          end else begin
            cmd.init_ins = 1'b1;
            state_next   = S_INS_RD;
          end
        end else begin
          if (sts.bad_index) begin
            state_next = S_FIN;
          end else begin
            cmd.init_rem = 1'b1;
            state_next   = S_REM_RD0;
          end
        end
      end
      S_INS_RD: begin
        if (sts.ptr_zero) begin
          cmd.wr_new = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.rd_below = 1'b1;
          state_next   = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.key_greater) begin
          cmd.wr_up  = 1'b1;
          state_next = S_INS_RD;
        end else begin
          cmd.wr_new = 1'b1;
          state_next = S_FIN;
        end
      end
      S_REM_RD0: begin
        cmd.rd_at  = 1'b1;
        state_next = S_REM_CAP;
      end
      S_REM_CAP: begin
        cmd.cap_removed = 1'b1;
        state_next      = S_REM_RD;
      end
      S_REM_RD: begin
        if (sts.rem_last) begin
          state_next = S_FIN;
        end else begin
          cmd.rd_above = 1'b1;
          state_next   = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        cmd.wr_down = 1'b1;
        state_next  = S_REM_RD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `SAQ_ASSERT_NEXT(a_accept_check, s_tvalid && s_tready, state == S_CHECK,
                   "accept not followed by check")
  `SAQ_ASSERT_NEXT(a_fin_hold, (state == S_FIN) && !sts.out_free, state == S_FIN,
                   "result dropped while output busy")
  `SAQ_ASSERT_IMP(a_one_write, 1'b1,
                  $countones({cmd.wr_new, cmd.wr_up, cmd.wr_down}) <= 1,
                  "two memory writes in one cycle")

endmodule

### hdl/saq_dp.sv
// Datapath of the sorted arrival queue: entry memory, pointer, count, result register.
`include "sorted_arrival_queue_assert.svh"

module saq_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  saq_pkg::cmd_t                    cmd,
  output saq_pkg::sts_t                    sts,
  input  logic [saq_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [saq_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import saq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > CNT_W) ? CW : CNT_W;

  // latched operation
  logic             op_kind;
  logic [KEY_W-1:0] op_key;
  logic [TAG_W-1:0] op_tag;
  logic [IDX_W-1:0] op_idx;

  logic [CW-1:0] count;
  logic [IW-1:0] ptr;
  entry_t        rd_data;
  entry_t        rem_entry;
  entry_t        mem [CAPACITY];

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  entry_t        wr_data;

  logic [XW-1:0]       idx_ext;
  logic [XW-1:0]       count_ext;
  logic [XW-1:0]       slot_ext;
  logic [XW-1:0]       count_res;
  logic [STATUS_W-1:0] res_status;
  logic                res_ok;
  logic [SLOT_W-1:0]   res_slot;
  entry_t              res_entry;

  assign idx_ext   = XW'(op_idx);
  assign count_ext = XW'(count);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind <= s_tuser;
      op_key  <= s_tdata[KEY_W-1:0];
      op_tag  <= s_tdata[KEY_W+TAG_W-1:KEY_W];
      op_idx  <= s_tdata[KEY_W+TAG_W+IDX_W-1:KEY_W+TAG_W];
    end
  end

  // entry memory: one write, one registered read per cycle
  assign rd_en   = cmd.rd_below | cmd.rd_at | cmd.rd_above;
  assign rd_addr = cmd.rd_below ? (ptr - IW'(1)) :
                   cmd.rd_above ? (ptr + IW'(1)) : ptr;
  assign wr_en   = cmd.wr_new | cmd.wr_up | cmd.wr_down;
  assign wr_data = cmd.wr_new ? entry_t'({op_key, op_tag}) : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ptr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_ins) begin
      ptr <= count[IW-1:0];
    end else if (cmd.init_rem) begin
      ptr <= idx_ext[IW-1:0];
    end else if (cmd.wr_up) begin
      ptr <= ptr - IW'(1);
    end else if (cmd.wr_down) begin
      ptr <= ptr + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_removed) begin
      rem_entry <= rd_data;
    end
  end

  // status
  always_comb begin
    sts.is_insert   = (op_kind == KIND_INSERT);
    sts.full        = (count == CW'(CAPACITY));
    sts.bad_index   = (idx_ext >= count_ext);
    sts.ptr_zero    = (ptr == '0);
    sts.key_greater = (rd_data.key > op_key);
    sts.rem_last    = ((CW'(ptr) + CW'(1)) >= count);
    sts.out_free    = !m_tvalid || m_tready;
  end

  // result
  always_comb begin
    if (sts.is_insert) begin
      res_status = sts.full ? STATUS_FULL : STATUS_OK;
      slot_ext   = XW'(ptr);
    end else begin
      res_status = sts.bad_index ? STATUS_RANGE : STATUS_OK;
      slot_ext   = idx_ext;
    end
    res_ok    = (res_status == STATUS_OK);
    res_slot  = res_ok ? slot_ext[SLOT_W-1:0] : '0;
    res_entry = (res_ok && !sts.is_insert) ? rem_entry : '0;
    if (!res_ok) begin
      count_res = count_ext;
    end else if (sts.is_insert) begin
      count_res = count_ext + XW'(1);
    end else begin
      count_res = count_ext - XW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load_result) begin
      count <= count_res[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      m_tdata <= {(OUT_TDATA_W - OUT_USED_W)'(0), count_res[CNT_W-1:0],
                  res_entry.tag, res_entry.key, res_slot, res_status};
    end
  end

  `SAQ_ASSERT_IMP(a_count_max, 1'b1, count <= CW'(CAPACITY), "entry count above capacity")
  `SAQ_ASSERT_IMP(a_load_free, cmd.load_result, !m_tvalid || m_tready, "result register overwritten")
  `SAQ_ASSERT_NEXT(a_count_inc, cmd.load_result && sts.is_insert && !sts.full, count == $past(count) + CW'(1), "insert did not bump count")

endmodule

### hdl/sorted_arrival_queue.sv
// Top level of the sorted arrival queue: controller plus datapath.
// Usage:
//   Input stream (s_*): one beat per operation. s_tuser is the kind,
//   0 insert, 1 remove. Insert places (arrival_key, entry_tag) after every
//   held entry with an equal or smaller key; remove takes remove_index out
//   and closes the gap.
//   Output stream (m_*): exactly one result beat per input beat, in order:
//   status, slot, removed key/tag and entry count after the operation.
//   Data movement: entries move one at a time through the entry memory (one
//   registered read and one write per cycle); an insert shifts up each
//   held entry above its slot, a remove shifts down each entry above its
//   index, and a full or out-of-range request moves no entry.
//   Flow: one operation in flight; s_tready is high only while idle,
//   so the next beat can be taken in the cycle after the result is loaded.
//   The result sits in an output register, so the next beat is accepted
//   while it waits; a new result is held back until m_tready frees it.
//   Reset: rst (synchronous) empties the queue and clears the output valid;
//   entry contents need no clearing since only slots below count are read.
module sorted_arrival_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] arrival_key, [23:16] entry_tag, [27:24] remove_index, rest zero
  input  logic [saq_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [0] kind
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] status, [5:2] slot, [21:6] removed_key, [29:22] removed_tag,
  // [34:30] entry_count, rest zero
  output logic [saq_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import saq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  saq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  saq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
